// ===== sv/ilist_pkg.sv =====
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared sizes, codes, state encoding and port bundles of the indexed ordered
// list unit.
// ----------------------------------------------------------------------------
package ilist_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int POS_W      = 7;
  localparam int ITEM_POS_W = 6;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;

  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [REQ_W-1:0]             req_t;
  typedef logic [STATUS_W-1:0]          status_t;

  localparam idx_t NULL_IDX = idx_t'(CAPACITY);
  localparam idx_t LAST_IDX = idx_t'(CAPACITY - 1);

  localparam req_t REQ_INSERT = 2'd0;
  localparam req_t REQ_DELETE = 2'd1;
  localparam req_t REQ_DUMP   = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_OOB   = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_INS_FREE,
    S_WALK,
    S_INS_LINK,
    S_INS_SET,
    S_DEL_HEAD,
    S_DEL_VICT,
    S_DEL_LINK,
    S_DEL_FREE,
    S_DUMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    idx_t  wdata;
    logic  re;
    addr_t raddr;
  } link_port_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    data_t wdata;
    logic  re;
    addr_t raddr;
  } val_port_t;

  typedef struct packed {
    status_t                 status;
    data_t                   value_out;
    logic [ITEM_POS_W-1:0]   item_pos;
    logic                    last;
  } rsp_t;

endpackage

// ===== sv/ilist_req_if.sv =====
// ----------------------------------------------------------------------------
// ilist_req_if
// Request channel: valid/ready handshake with request type, position, value.
// ----------------------------------------------------------------------------
interface ilist_req_if;
  logic                          valid;
  logic                          ready;
  logic [ilist_pkg::REQ_W-1:0]   req_type;
  logic [ilist_pkg::POS_W-1:0]   position;
  ilist_pkg::data_t              value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink   (input valid, req_type, position, value, output ready);
endinterface

// ===== sv/ilist_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ilist_rsp_if
// Result channel: valid/ready handshake with status, value, position, last.
// ----------------------------------------------------------------------------
interface ilist_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ilist_pkg::STATUS_W-1:0]    status;
  ilist_pkg::data_t                  value_out;
  logic [ilist_pkg::ITEM_POS_W-1:0]  item_pos;
  logic                              last;

  modport source (output valid, status, value_out, item_pos, last, input ready);
  modport sink   (input valid, status, value_out, item_pos, last, output ready);
endinterface

// ===== sv/ilist_ram.sv =====
// ----------------------------------------------------------------------------
// ilist_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module ilist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ilist_obuf.sv =====
// ----------------------------------------------------------------------------
// ilist_obuf
// Output register of the result channel; frees the sequencer while a beat
// waits for the receiver.
// ----------------------------------------------------------------------------
module ilist_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ilist_pkg::rsp_t    rsp,
  output logic               space,
  ilist_rsp_if.source        out_rsp
);

  logic            valid_r;
  logic            valid_nxt;
  ilist_pkg::rsp_t data_r;

  assign space = !valid_r || out_rsp.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push && space) begin
      valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && space) begin
      data_r <= rsp;
    end
  end

  assign out_rsp.valid     = valid_r;
  assign out_rsp.status    = data_r.status;
  assign out_rsp.value_out = data_r.value_out;
  assign out_rsp.item_pos  = data_r.item_pos;
  assign out_rsp.last      = data_r.last;

endmodule

// ===== sv/ilist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilist_ctrl
// Request sequencer: checks a request, walks the link store one entry per
// cycle, and reads, modifies and writes back the link and value stores.
// ----------------------------------------------------------------------------
module ilist_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  ilist_req_if.sink               in_req,
  output ilist_pkg::link_port_t   lnk,
  input  ilist_pkg::idx_t         lnk_rdata,
  output ilist_pkg::val_port_t    val,
  input  ilist_pkg::data_t        val_rdata,
  output logic                    push,
  output ilist_pkg::rsp_t         rsp,
  input  logic                    space
);

  ilist_pkg::state_t  state_r,  state_nxt;
  ilist_pkg::idx_t    head_r,   head_nxt;
  ilist_pkg::idx_t    free_r,   free_nxt;
  ilist_pkg::idx_t    len_r,    len_nxt;
  ilist_pkg::idx_t    init_r,   init_nxt;
  ilist_pkg::req_t    op_r,     op_nxt;
  ilist_pkg::idx_t    pos_r,    pos_nxt;
  ilist_pkg::data_t   val_r,    val_nxt;
  ilist_pkg::idx_t    cur_r,    cur_nxt;
  ilist_pkg::idx_t    cnt_r,    cnt_nxt;
  ilist_pkg::idx_t    node_r,   node_nxt;
  ilist_pkg::status_t status_r, status_nxt;

  ilist_pkg::idx_t    in_pos;
  ilist_pkg::idx_t    steps;
  logic               dump_last;

  assign in_pos    = ilist_pkg::idx_t'(in_req.position);
  assign steps     = (state_r == ilist_pkg::S_IDLE) ? in_pos - 1'b1 : pos_r - 1'b1;
  assign dump_last = (cnt_r == len_r - 1'b1);

  assign in_req.ready = (state_r == ilist_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    free_nxt   = free_r;
    len_nxt    = len_r;
    init_nxt   = init_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    node_nxt   = node_r;
    status_nxt = status_r;
    lnk        = '0;
    val        = '0;
    push       = 1'b0;
    rsp        = '0;

    case (state_r)
      ilist_pkg::S_INIT: begin
        // chain every entry into the free list
        lnk.we    = 1'b1;
        lnk.waddr = init_r[ilist_pkg::ADDR_W-1:0];
        lnk.wdata = init_r + 1'b1;
        init_nxt  = init_r + 1'b1;
        if (init_r == ilist_pkg::LAST_IDX) begin
          state_nxt = ilist_pkg::S_IDLE;
        end
      end

      ilist_pkg::S_IDLE: begin
        if (in_req.valid) begin
          op_nxt  = in_req.req_type;
          pos_nxt = in_pos;
          val_nxt = in_req.value;
          case (in_req.req_type)
            ilist_pkg::REQ_INSERT: begin
              if (len_r == ilist_pkg::NULL_IDX || free_r >= ilist_pkg::NULL_IDX) begin
                status_nxt = ilist_pkg::ST_FULL;
                state_nxt  = ilist_pkg::S_RESP;
              end else if (len_r == '0 && in_pos != '0) begin
                status_nxt = ilist_pkg::ST_EMPTY;
                state_nxt  = ilist_pkg::S_RESP;
              end else if (in_pos > len_r) begin
                status_nxt = ilist_pkg::ST_OOB;
                state_nxt  = ilist_pkg::S_RESP;
              end else begin
                lnk.re    = 1'b1;
                lnk.raddr = free_r[ilist_pkg::ADDR_W-1:0];
                state_nxt = ilist_pkg::S_INS_FREE;
              end
            end
            ilist_pkg::REQ_DELETE: begin
              if (len_r == '0 || head_r >= ilist_pkg::NULL_IDX) begin
                status_nxt = ilist_pkg::ST_EMPTY;
                state_nxt  = ilist_pkg::S_RESP;
              end else if (in_pos >= len_r) begin
                status_nxt = ilist_pkg::ST_OOB;
                state_nxt  = ilist_pkg::S_RESP;
              end else begin
                lnk.re    = 1'b1;
                lnk.raddr = head_r[ilist_pkg::ADDR_W-1:0];
                cur_nxt   = head_r;
                if (in_pos == '0) begin
                  node_nxt  = head_r;
                  state_nxt = ilist_pkg::S_DEL_HEAD;
                end else if (steps == '0) begin
                  state_nxt = ilist_pkg::S_DEL_VICT;
                end else begin
                  cnt_nxt   = steps;
                  state_nxt = ilist_pkg::S_WALK;
                end
              end
            end
            ilist_pkg::REQ_DUMP: begin
              if (len_r == '0 || head_r >= ilist_pkg::NULL_IDX) begin
                status_nxt = ilist_pkg::ST_EMPTY;
                state_nxt  = ilist_pkg::S_RESP;
              end else begin
                lnk.re    = 1'b1;
                lnk.raddr = head_r[ilist_pkg::ADDR_W-1:0];
                val.re    = 1'b1;
                val.raddr = head_r[ilist_pkg::ADDR_W-1:0];
                cnt_nxt   = '0;
                state_nxt = ilist_pkg::S_DUMP;
              end
            end
            default: begin
              state_nxt = ilist_pkg::S_IDLE;
            end
          endcase
        end
      end

      ilist_pkg::S_INS_FREE: begin
        // lnk_rdata is the successor of the allocated entry on the free list
        node_nxt  = free_r;
        free_nxt  = lnk_rdata;
        val.we    = 1'b1;
        val.waddr = free_r[ilist_pkg::ADDR_W-1:0];
        val.wdata = val_r;
        if (pos_r == '0) begin
          lnk.we     = 1'b1;
          lnk.waddr  = free_r[ilist_pkg::ADDR_W-1:0];
          lnk.wdata  = head_r;
          head_nxt   = free_r;
          len_nxt    = len_r + 1'b1;
          status_nxt = ilist_pkg::ST_OK;
          state_nxt  = ilist_pkg::S_RESP;
        end else begin
          lnk.re    = 1'b1;
          lnk.raddr = head_r[ilist_pkg::ADDR_W-1:0];
          cur_nxt   = head_r;
          if (steps == '0) begin
            state_nxt = ilist_pkg::S_INS_LINK;
          end else begin
            cnt_nxt   = steps;
            state_nxt = ilist_pkg::S_WALK;
          end
        end
      end

      ilist_pkg::S_WALK: begin
        // one link per cycle; the read of the next link is issued at once
        cur_nxt   = lnk_rdata;
        lnk.re    = 1'b1;
        lnk.raddr = lnk_rdata[ilist_pkg::ADDR_W-1:0];
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == ilist_pkg::idx_t'(1)) begin
          state_nxt = (op_r == ilist_pkg::REQ_INSERT) ? ilist_pkg::S_INS_LINK
                                                       : ilist_pkg::S_DEL_VICT;
        end
      end

      ilist_pkg::S_INS_LINK: begin
        lnk.we    = 1'b1;
        lnk.waddr = node_r[ilist_pkg::ADDR_W-1:0];
        lnk.wdata = lnk_rdata;
        state_nxt = ilist_pkg::S_INS_SET;
      end

      ilist_pkg::S_INS_SET: begin
        lnk.we     = 1'b1;
        lnk.waddr  = cur_r[ilist_pkg::ADDR_W-1:0];
        lnk.wdata  = node_r;
        len_nxt    = len_r + 1'b1;
        status_nxt = ilist_pkg::ST_OK;
        state_nxt  = ilist_pkg::S_RESP;
      end

      ilist_pkg::S_DEL_HEAD: begin
        head_nxt  = lnk_rdata;
        state_nxt = ilist_pkg::S_DEL_FREE;
      end

      ilist_pkg::S_DEL_VICT: begin
        node_nxt  = lnk_rdata;
        lnk.re    = 1'b1;
        lnk.raddr = lnk_rdata[ilist_pkg::ADDR_W-1:0];
        state_nxt = ilist_pkg::S_DEL_LINK;
      end

      ilist_pkg::S_DEL_LINK: begin
        lnk.we    = 1'b1;
        lnk.waddr = cur_r[ilist_pkg::ADDR_W-1:0];
        lnk.wdata = lnk_rdata;
        state_nxt = ilist_pkg::S_DEL_FREE;
      end

      ilist_pkg::S_DEL_FREE: begin
        lnk.we     = 1'b1;
        lnk.waddr  = node_r[ilist_pkg::ADDR_W-1:0];
        lnk.wdata  = free_r;
        free_nxt   = node_r;
        len_nxt    = len_r - 1'b1;
        status_nxt = ilist_pkg::ST_OK;
        state_nxt  = ilist_pkg::S_RESP;
      end

      ilist_pkg::S_DUMP: begin
        push          = 1'b1;
        rsp.status    = ilist_pkg::ST_OK;
        rsp.value_out = val_rdata;
        rsp.item_pos  = cnt_r[ilist_pkg::ITEM_POS_W-1:0];
        rsp.last      = dump_last;
        if (space) begin
          if (dump_last) begin
            state_nxt = ilist_pkg::S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            lnk.re    = 1'b1;
            lnk.raddr = lnk_rdata[ilist_pkg::ADDR_W-1:0];
            val.re    = 1'b1;
            val.raddr = lnk_rdata[ilist_pkg::ADDR_W-1:0];
          end
        end
      end

      ilist_pkg::S_RESP: begin
        push       = 1'b1;
        rsp.status = status_r;
        rsp.last   = 1'b1;
        if (space) begin
          state_nxt = ilist_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ilist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilist_pkg::S_INIT;
      head_r  <= ilist_pkg::NULL_IDX;
      free_r  <= '0;
      len_r   <= '0;
      init_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      free_r  <= free_nxt;
      len_r   <= len_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    node_r   <= node_nxt;
    status_r <= status_nxt;
  end

endmodule

// ===== sv/indexed_ordered_list_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_ordered_list_unit
// Ordered list of signed values kept in a linked store with a free chain.
//
// in_req carries one request per beat: insert a value at a position, delete
// the entry at a position, or dump the whole list. out_rsp carries results:
// one beat with a status for insert and delete, one beat per entry for a
// dump (status ok, value and position, last on the final entry), or a single
// status beat when the list is empty. Request type 3 is taken and dropped.
// One request is worked on at a time; in_req.ready is high only while idle.
// An insert or a delete at position p > 0 walks the list from the head: the
// walk follows one link per cycle through the link store's single read port.
// A dump gives one beat per cycle while the output register has space.
// After reset a pass chains every entry of the link store into the free
// list; no request is taken before it ends. A result beat waits in an output
// register; while the receiver stalls the sequencer holds its read data and
// resumes when the register frees.
// ----------------------------------------------------------------------------
module indexed_ordered_list_unit (
  input  logic          clk,
  input  logic          rst_n,
  ilist_req_if.sink     in_req,
  ilist_rsp_if.source   out_rsp
);

  ilist_pkg::link_port_t lnk;
  ilist_pkg::val_port_t  val;
  ilist_pkg::idx_t       lnk_rdata;
  ilist_pkg::data_t      val_rdata;
  ilist_pkg::rsp_t       rsp;
  logic                  push;
  logic                  space;

  ilist_ram #(
    .WIDTH (ilist_pkg::IDX_W),
    .DEPTH (ilist_pkg::CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (lnk.we),
    .waddr (lnk.waddr),
    .wdata (lnk.wdata),
    .re    (lnk.re),
    .raddr (lnk.raddr),
    .rdata (lnk_rdata)
  );

  ilist_ram #(
    .WIDTH (ilist_pkg::DATA_WIDTH),
    .DEPTH (ilist_pkg::CAPACITY)
  ) u_value_ram (
    .clk   (clk),
    .we    (val.we),
    .waddr (val.waddr),
    .wdata (val.wdata),
    .re    (val.re),
    .raddr (val.raddr),
    .rdata (val_rdata)
  );

  ilist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .lnk       (lnk),
    .lnk_rdata (lnk_rdata),
    .val       (val),
    .val_rdata (val_rdata),
    .push      (push),
    .rsp       (rsp),
    .space     (space)
  );

  ilist_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rsp     (rsp),
    .space   (space),
    .out_rsp (out_rsp)
  );

endmodule

// ===== tb/indexed_ordered_list_unit_test.sv =====
// ----------------------------------------------------------------------------
// indexed_ordered_list_unit_test
// Self-checking bench for the indexed ordered list unit. A queue-based copy
// of the list predicts every result beat of each accepted request. A short
// table of directed requests comes first: empty list, bounds, extreme
// values and the ignored request type. Random traffic follows, with fill to
// full, drain to empty and mixed phases. Bursty requests and a patterned
// result stall run alongside, with long result hold-offs that back the unit
// up into its request port.
// ----------------------------------------------------------------------------
module indexed_ordered_list_unit_test;
  import ilist_pkg::*;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    req_t    req;
    pos_t    pos;
    data_t   val;
    logic    typed;
    status_t st;
  } dir_row_t;

  localparam req_t  REQ_UNUSED   = 2'd3;
  localparam data_t DATA_MIN     = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam data_t DATA_MAX     = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam int    RANDOM_ITEMS = 500;
  localparam int    DRAIN_CYCLES = CAPACITY + 40;
  localparam int    HOLD_CYCLES  = 400;
  localparam int    DIR_N        = 18;

  logic clk;
  logic rst_n;

  ilist_req_if in_req();
  ilist_rsp_if out_rsp();

  indexed_ordered_list_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  data_t list_contents[$];
  rsp_t  awaited_rsp[$];

  int errors;
  int beats_seen;
  int reqs_accepted;
  int n_ins;
  int n_del;
  int n_dump;
  int peak_len;
  int burst_left;
  int st_hits[4];

  dir_row_t dir_tab [DIR_N] = '{
    '{REQ_DUMP,   7'd0,   '0,                1'b1, ST_EMPTY},
    '{REQ_DELETE, 7'd0,   '0,                1'b1, ST_EMPTY},
    '{REQ_INSERT, 7'd5,   DATA_MAX,          1'b1, ST_EMPTY},
    '{REQ_INSERT, 7'd127, DATA_MIN,          1'b1, ST_EMPTY},
    '{REQ_INSERT, 7'd0,   DATA_MIN,          1'b1, ST_OK},
    '{REQ_INSERT, 7'd1,   DATA_MAX,          1'b1, ST_OK},
    '{REQ_INSERT, 7'd3,   '0,                1'b1, ST_OOB},
    '{REQ_INSERT, 7'd1,   '0,                1'b0, ST_OK},
    '{REQ_INSERT, 7'd0,   '1,                1'b0, ST_OK},
    '{REQ_DUMP,   7'd0,   '0,                1'b0, ST_OK},
    '{REQ_DELETE, 7'd4,   '0,                1'b1, ST_OOB},
    '{REQ_DELETE, 7'd127, '0,                1'b1, ST_OOB},
    '{REQ_UNUSED, 7'd127, DATA_MAX,          1'b0, ST_OK},
    '{REQ_DELETE, 7'd3,   '0,                1'b0, ST_OK},
    '{REQ_DELETE, 7'd1,   '0,                1'b0, ST_OK},
    '{REQ_INSERT, 7'd2,   32'sh5a5a_a5a5,    1'b0, ST_OK},
    '{REQ_DELETE, 7'd0,   '0,                1'b0, ST_OK},
    '{REQ_DUMP,   7'd0,   '0,                1'b0, ST_OK}
  };

  function automatic void list_update(input req_t r, input pos_t p, input data_t v,
                                      ref rsp_t res[$]);
    rsp_t one;
    int   n;
    res.delete();
    n = list_contents.size();
    one = '{status: ST_OK, value_out: '0, item_pos: '0, last: 1'b1};
    case (r)
      REQ_INSERT: begin
        if (n >= CAPACITY) one.status = ST_FULL;
        else if (n == 0 && p != 0) one.status = ST_EMPTY;
        else if (p > n) one.status = ST_OOB;
        else list_contents.insert(p, v);
        res.push_back(one);
      end
      REQ_DELETE: begin
        if (n == 0) one.status = ST_EMPTY;
        else if (p >= n) one.status = ST_OOB;
        else list_contents.delete(p);
        res.push_back(one);
      end
      REQ_DUMP: begin
        if (n == 0) begin
          one.status = ST_EMPTY;
          res.push_back(one);
        end else begin
          for (int i = 0; i < n; i++) begin
            one.value_out = list_contents[i];
            one.item_pos  = ITEM_POS_W'(i);
            one.last      = (i == n - 1);
            res.push_back(one);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic data_t rand_value();
    case ($urandom_range(0, 7))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return '0;
      3: return '1;
      default: return data_t'($urandom);
    endcase
  endfunction

  // mostly legal positions, with ends favored and some out-of-range noise
  function automatic pos_t rand_pos(input int hi);
    if (hi < 0) hi = 0;
    if ($urandom_range(0, 9) == 0) return pos_t'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return pos_t'(hi);
      default: return pos_t'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic send_request(input req_t r, input pos_t p, input data_t v,
                              input logic typed, input status_t st);
    rsp_t res[$];
    int   gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_req.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_req.valid    = 1'b1;
    in_req.req_type = r;
    in_req.position = p;
    in_req.value    = v;
    do @(posedge clk); while (!in_req.ready);
    list_update(r, p, v, res);
    if (typed) begin
      res.delete();
      res.push_back(rsp_t'{status: st, value_out: '0, item_pos: '0, last: 1'b1});
    end
    foreach (res[i]) awaited_rsp.push_back(res[i]);
    reqs_accepted++;
    case (r)
      REQ_INSERT: n_ins++;
      REQ_DELETE: n_del++;
      REQ_DUMP:   n_dump++;
      default: ;
    endcase
    if (list_contents.size() > peak_len) peak_len = list_contents.size();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("indexed_ordered_list_unit_test: errors");
    $finish;
  end

  initial begin : stimulus
    int   sent;
    int   kind;
    int   n;
    pos_t p;
    rst_n           = 1'b0;
    in_req.valid    = 1'b0;
    in_req.req_type = REQ_INSERT;
    in_req.position = '0;
    in_req.value    = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i].req, dir_tab[i].pos, dir_tab[i].val, dir_tab[i].typed,
                   dir_tab[i].st);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
        // fill to capacity, then push against the full store
        while (list_contents.size() < CAPACITY) begin
          send_request(REQ_INSERT, rand_pos(list_contents.size()), rand_value(), 1'b0, ST_OK);
          sent++;
        end
        send_request(REQ_INSERT, pos_t'(CAPACITY), rand_value(), 1'b0, ST_OK);
        send_request(REQ_INSERT, pos_t'($urandom_range(0, 127)), rand_value(), 1'b0, ST_OK);
        send_request(REQ_DUMP, pos_t'($urandom_range(0, 127)), rand_value(), 1'b0, ST_OK);
        sent += 3;
      end else if (kind == 1) begin
        // drain to empty
        while (list_contents.size() > 0) begin
          send_request(REQ_DELETE, rand_pos(list_contents.size() - 1), rand_value(), 1'b0,
                       ST_OK);
          sent++;
        end
        send_request(REQ_DELETE, pos_t'($urandom_range(0, 127)), rand_value(), 1'b0, ST_OK);
        send_request(REQ_DUMP, '0, rand_value(), 1'b0, ST_OK);
        sent += 2;
      end else begin
        repeat ($urandom_range(8, 30)) begin
          n = list_contents.size();
          kind = $urandom_range(0, 99);
          p = pos_t'($urandom_range(0, 127));
          if (kind < 45) begin
            send_request(REQ_INSERT, rand_pos(n), rand_value(), 1'b0, ST_OK);
            sent++;
          end else if (kind < 82) begin
            send_request(REQ_DELETE, rand_pos(n - 1), rand_value(), 1'b0, ST_OK);
            sent++;
          end else if (kind < 90) begin
            send_request(REQ_DUMP, p, rand_value(), 1'b0, ST_OK);
            sent++;
          end else if (kind < 95) begin
            send_request(REQ_UNUSED, p, rand_value(), 1'b0, ST_OK);
          end else begin
            send_request(($urandom_range(0, 1) == 0) ? REQ_INSERT : REQ_DELETE, p,
                         rand_value(), 1'b0, ST_OK);
            sent++;
          end
        end
      end
    end

    @(negedge clk);
    in_req.valid = 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d inserts, %0d deletes, %0d dumps and %0d result beats",
             n_ins, n_del, n_dump, beats_seen);
    $display("list grew to %0d of %0d; status ok %0d, empty %0d, bounds %0d, full %0d",
             peak_len, CAPACITY, st_hits[ST_OK], st_hits[ST_EMPTY], st_hits[ST_OOB],
             st_hits[ST_FULL]);
    if (errors == 0) begin
      $display("indexed_ordered_list_unit_test: clean");
    end else begin
      $display("indexed_ordered_list_unit_test: errors");
    end
    $finish;
  end

  initial begin : receiver
    int         cyc;
    int         hold_left;
    logic [7:0] mask;
    bit         hold1_done;
    bit         hold2_done;
    cyc           = 0;
    hold_left     = 0;
    mask          = 8'hFF;
    hold1_done    = 1'b0;
    hold2_done    = 1'b0;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold1_done && reqs_accepted >= 120) begin
        hold1_done = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (!hold2_done && reqs_accepted >= 400) begin
        hold2_done = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (cyc % 32 == 0) begin
        mask = ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      end
      if (hold_left > 0) begin
        out_rsp.ready = 1'b0;
        hold_left--;
      end else begin
        out_rsp.ready = mask[cyc % 8];
      end
      cyc++;
    end
  end

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      beats_seen++;
      if (awaited_rsp.size() == 0) begin
        $error("result beat with nothing awaited: status %0d value %0d pos %0d last %0b",
               out_rsp.status, out_rsp.value_out, out_rsp.item_pos, out_rsp.last);
        errors++;
      end else begin
        want = awaited_rsp.pop_front();
        st_hits[want.status]++;
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          errors++;
        end
        if (out_rsp.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, out_rsp.value_out);
          errors++;
        end
        if (out_rsp.item_pos !== want.item_pos) begin
          $error("item_pos: expected %0d, got %0d", want.item_pos, out_rsp.item_pos);
          errors++;
        end
        if (out_rsp.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_rsp.last);
          errors++;
        end
      end
    end
  end

endmodule

// ===== sim.f =====
sv/ilist_pkg.sv
sv/ilist_req_if.sv
sv/ilist_rsp_if.sv
sv/ilist_ram.sv
sv/ilist_obuf.sv
sv/ilist_ctrl.sv
sv/indexed_ordered_list_unit.sv
tb/indexed_ordered_list_unit_test.sv
